// ===== sv/damped_spring_force_3d_core_defines.svh =====
// ---------------------------------------------------------------------------
// damped spring force core: assertion macros
// shared property forms for the checks at the end of the top level
// ---------------------------------------------------------------------------
`ifndef DAMPED_SPRING_FORCE_3D_CORE_DEFINES_SVH
`define DAMPED_SPRING_FORCE_3D_CORE_DEFINES_SVH

// same-cycle implication
`define DSF_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define DSF_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/dsf_pkg.sv =====
// ---------------------------------------------------------------------------
// dsf_pkg
// widths, codes and shared types of the damped spring force core
// ---------------------------------------------------------------------------
package dsf_pkg;

  localparam int CW    = 32;                       // coordinate word
  localparam int FB    = 16;                       // fraction bits
  localparam int CFGW  = 32;                       // register word
  localparam int NAXIS = 3;
  localparam int DW    = CW + 1;                   // separation
  localparam int SQW   = 2 * CW + 2;               // sum of squares
  localparam int RTW   = SQW / 2;                  // distance
  localparam int REMW  = RTW + 3;                  // root remainder
  localparam int QW    = FB + 1;                   // unit component
  localparam int PW    = CW + 2;                   // projected speed
  localparam int STW   = ((RTW > CFGW) ? RTW : CFGW) + 1;
  localparam int AW    = (PW > STW) ? PW : STW;    // multiplicand
  localparam int NDIG  = 3;
  localparam int BNEED = (DW > CFGW) ? DW : CFGW;
  localparam int DG    = (BNEED + NDIG - 1) / NDIG;
  localparam int BW    = NDIG * DG;                // multiplier
  localparam int ACW   = AW + BW + 2;              // accumulator
  localparam int MW    = CW - 1;                   // saturated magnitude
  localparam int SW    = MW + 2;                   // force sum
  localparam int CNTW  = $clog2(RTW + 1);
  localparam int DIGW  = $clog2(NDIG);
  localparam int AXW   = $clog2(NAXIS);
  localparam int CIDXW = 2;

  localparam logic [MW-1:0]   SAT_MAX   = '1;
  localparam logic [AXW-1:0]  LAST_AXIS = AXW'(NAXIS - 1);
  localparam logic [DIGW-1:0] LAST_DIG  = DIGW'(NDIG - 1);
  localparam logic [CNTW-1:0] SQ_LAST   = CNTW'(RTW - 1);
  localparam logic [CNTW-1:0] DV_LAST   = CNTW'(QW - 1);

  typedef enum logic [CIDXW-1:0] {
    REG_STIFFNESS = 2'd0,
    REG_DAMPING   = 2'd1,
    REG_REST      = 2'd2,
    REG_ENABLE    = 2'd3
  } cfg_reg_t;

  typedef enum logic [3:0] {
    OP_NONE, OP_LOAD, OP_MAC, OP_SQRT_INIT, OP_SQRT_STEP, OP_DIV_INIT,
    OP_DIV_STEP, OP_DOT_SAVE, OP_SPR_SAVE, OP_DMP_SAVE, OP_FRC_SAVE, OP_OUT
  } op_t;

  typedef enum logic [2:0] {
    SRC_SQ, SRC_DOT, SRC_SPR, SRC_DMP, SRC_FRC
  } src_t;

  typedef enum logic [3:0] {
    S_IDLE, S_SQ, S_SQRTI, S_SQRT, S_DIVI, S_DIV, S_DOT, S_DOTSV,
    S_SPR, S_SPRSV, S_DMP, S_DMPSV, S_FRC, S_FRCSV, S_FIN
  } state_t;

  typedef struct packed {
    op_t             op;
    src_t            src;
    logic [AXW-1:0]  idx;
    logic [DIGW-1:0] dig;
    logic            clr;
  } cmd_t;

  typedef struct packed {
    logic second;
    logic go;
  } status_t;

  typedef struct packed {
    logic          end_select;
    logic [CW-1:0] pos_x;
    logic [CW-1:0] pos_y;
    logic [CW-1:0] pos_z;
    logic [CW-1:0] vel_x;
    logic [CW-1:0] vel_y;
    logic [CW-1:0] vel_z;
    logic          particle_free;
  } in_item_t;

  typedef struct packed {
    logic [CW-1:0] force_x;
    logic [CW-1:0] force_y;
    logic [CW-1:0] force_z;
    logic          apply_to_first;
    logic          apply_to_second;
  } out_item_t;

endpackage

// ===== sv/dsf_if.sv =====
// ---------------------------------------------------------------------------
// dsf channel interfaces
// particle item, force result and register write channels
// ---------------------------------------------------------------------------
interface dsf_item_if;
  import dsf_pkg::*;
  logic          valid;
  logic          ready;
  logic          end_select;
  logic [CW-1:0] pos_x;
  logic [CW-1:0] pos_y;
  logic [CW-1:0] pos_z;
  logic [CW-1:0] vel_x;
  logic [CW-1:0] vel_y;
  logic [CW-1:0] vel_z;
  logic          particle_free;
  modport source (output valid, end_select, pos_x, pos_y, pos_z, vel_x, vel_y, vel_z,
                  particle_free, input ready);
  modport sink (input valid, end_select, pos_x, pos_y, pos_z, vel_x, vel_y, vel_z,
                particle_free, output ready);
endinterface

interface dsf_result_if;
  import dsf_pkg::*;
  logic          valid;
  logic          ready;
  logic [CW-1:0] force_x;
  logic [CW-1:0] force_y;
  logic [CW-1:0] force_z;
  logic          apply_to_first;
  logic          apply_to_second;
  modport source (output valid, force_x, force_y, force_z, apply_to_first,
                  apply_to_second, input ready);
  modport sink (input valid, force_x, force_y, force_z, apply_to_first,
                apply_to_second, output ready);
endinterface

interface dsf_cfg_if;
  import dsf_pkg::*;
  logic              valid;
  logic              ready;
  logic [CIDXW-1:0]  index;
  logic [CFGW-1:0]   data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== sv/dsf_ctrl.sv =====
// ---------------------------------------------------------------------------
// dsf_ctrl
// sequencer stepping the datapath through one spring computation
// ---------------------------------------------------------------------------
module dsf_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  output logic            out_valid,
  input  logic            out_ready,
  input  dsf_pkg::status_t status,
  output dsf_pkg::cmd_t   cmd
);
  import dsf_pkg::*;

  state_t          state, state_next;
  logic [CNTW-1:0] cnt, cnt_next;
  logic [AXW-1:0]  idx, idx_next;
  logic [DIGW-1:0] dig, dig_next;
  logic            out_valid_next;
  logic            dig_last;
  logic            out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= '0;
      idx       <= '0;
      dig       <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      cnt       <= cnt_next;
      idx       <= idx_next;
      dig       <= dig_next;
      out_valid <= out_valid_next;
    end
  end

  assign dig_last = (dig == LAST_DIG);
  assign out_free = !out_valid || out_ready;

  always_comb begin
    state_next     = state;
    cnt_next       = cnt;
    idx_next       = idx;
    dig_next       = dig;
    in_ready       = 1'b0;
    out_valid_next = out_valid && !out_ready;
    cmd            = '{op: OP_NONE, src: SRC_SQ, idx: idx, dig: dig, clr: 1'b0};
    unique case (state)
      S_IDLE: begin
        in_ready = !rst;
        idx_next = '0;
        dig_next = '0;
        if (in_valid && !rst) begin
          cmd.op = OP_LOAD;
          if (status.second) begin
            state_next = status.go ? S_SQ : S_FIN;
          end
        end
      end
      S_SQ, S_DOT: begin
        cmd.op  = OP_MAC;
        cmd.src = (state == S_SQ) ? SRC_SQ : SRC_DOT;
        cmd.clr = (dig == '0) && (idx == '0);
        dig_next = dig + 1'b1;
        if (dig_last) begin
          dig_next = '0;
          idx_next = idx + 1'b1;
          if (idx == LAST_AXIS) begin
            idx_next   = '0;
            state_next = (state == S_SQ) ? S_SQRTI : S_DOTSV;
          end
        end
      end
      S_SQRTI: begin
        cmd.op     = OP_SQRT_INIT;
        cnt_next   = '0;
        state_next = S_SQRT;
      end
      S_SQRT: begin
        cmd.op   = OP_SQRT_STEP;
        cnt_next = cnt + 1'b1;
        if (cnt == SQ_LAST) begin
          state_next = S_DIVI;
        end
      end
      S_DIVI: begin
        cmd.op     = OP_DIV_INIT;
        cnt_next   = '0;
        state_next = S_DIV;
      end
      S_DIV: begin
        cmd.op   = OP_DIV_STEP;
        cnt_next = cnt + 1'b1;
        if (cnt == DV_LAST) begin
          state_next = S_DOT;
        end
      end
      S_DOTSV: begin
        cmd.op     = OP_DOT_SAVE;
        state_next = S_SPR;
      end
      S_SPR, S_DMP, S_FRC: begin
        cmd.op   = OP_MAC;
        cmd.src  = (state == S_SPR) ? SRC_SPR : ((state == S_DMP) ? SRC_DMP : SRC_FRC);
        cmd.clr  = (dig == '0);
        dig_next = dig + 1'b1;
        if (dig_last) begin
          dig_next   = '0;
          state_next = (state == S_SPR) ? S_SPRSV : ((state == S_DMP) ? S_DMPSV : S_FRCSV);
        end
      end
      S_SPRSV: begin
        cmd.op     = OP_SPR_SAVE;
        state_next = S_DMP;
      end
      S_DMPSV: begin
        cmd.op     = OP_DMP_SAVE;
        idx_next   = '0;
        state_next = S_FRC;
      end
      S_FRCSV: begin
        cmd.op   = OP_FRC_SAVE;
        idx_next = idx + 1'b1;
        state_next = (idx == LAST_AXIS) ? S_FIN : S_FRC;
      end
      S_FIN: begin
        if (out_free) begin
          cmd.op         = OP_OUT;
          out_valid_next = 1'b1;
          state_next     = S_IDLE;
        end
      end
    endcase
  end

endmodule

// ===== sv/dsf_datapath.sv =====
// ---------------------------------------------------------------------------
// dsf_datapath
// held end, registers, shared multiplier, root and divider units, result
// ---------------------------------------------------------------------------
module dsf_datapath (
  input  logic                        clk,
  input  logic                        rst,
  input  dsf_pkg::cmd_t               cmd,
  output dsf_pkg::status_t            status,
  input  dsf_pkg::in_item_t           in_item,
  output dsf_pkg::out_item_t          out_item,
  input  logic                        cfg_valid,
  input  logic [dsf_pkg::CIDXW-1:0]   cfg_index,
  input  logic [dsf_pkg::CFGW-1:0]    cfg_data
);
  import dsf_pkg::*;

  function automatic logic [MW-1:0] sat_shift(input logic [ACW-1:0] v);
    if (|v[ACW-1:FB+MW]) return SAT_MAX;
    return v[FB +: MW];
  endfunction

  // configuration and held end
  logic [CFGW-1:0] stiff, dampf, rest;
  logic            en;
  logic [CW-1:0]   hv [2*NAXIS];
  logic            hfree, hvalid;

  // working registers
  logic [DW-1:0]   d [NAXIS];
  logic [DW-1:0]   dv [NAXIS];
  logic            bfree, zflag;
  logic [ACW-1:0]  acc;
  logic [SQW-1:0]  rad;
  logic [RTW-1:0]  root;
  logic [REMW-1:0] rem;
  logic [RTW-1:0]  dr [NAXIS];
  logic [QW-1:0]   q [NAXIS];
  logic            nb [NAXIS];
  logic [PW-1:0]   proj;
  logic            dneg, sneg, rneg;
  logic [MW-1:0]   smag, rmag;
  logic [CW-1:0]   f [NAXIS];

  // combinational
  logic [CW-1:0]   posv [NAXIS];
  logic [CW-1:0]   velv [NAXIS];
  logic [DW-1:0]   dmag [NAXIS];
  logic [DW-1:0]   dvmag [NAXIS];
  logic [QW-1:0]   umag [NAXIS];
  logic [STW-1:0]  stretch, stmag;
  logic [AW-1:0]   op_a;
  logic [BW-1:0]   op_b;
  logic            op_sub;
  logic [DG-1:0]   digit;
  logic [AW+DG-1:0] prod;
  logic [ACW-1:0]  addend, base, acc_abs;
  logic [REMW-1:0] rem_t, trial;
  logic [MW-1:0]   dmag_sat, fmag;
  logic [SW-1:0]   spr_s, dmp_s, rsum, rabs;
  logic            fneg;
  logic [CW-1:0]   fval;

  assign status.second = in_item.end_select;
  assign status.go     = hvalid && en && (hfree || in_item.particle_free);

  assign posv[0] = in_item.pos_x;
  assign posv[1] = in_item.pos_y;
  assign posv[2] = in_item.pos_z;
  assign velv[0] = in_item.vel_x;
  assign velv[1] = in_item.vel_y;
  assign velv[2] = in_item.vel_z;

  always_comb begin
    for (int i = 0; i < NAXIS; i++) begin
      dmag[i]  = d[i][DW-1] ? -d[i] : d[i];
      dvmag[i] = dv[i][DW-1] ? -dv[i] : dv[i];
      umag[i]  = (root == '0) ? '0 : q[i];
    end
  end

  assign stretch = STW'(root) - STW'(rest);
  assign stmag   = stretch[STW-1] ? -stretch : stretch;

  // operand selection for the shared multiplier
  always_comb begin
    op_a   = '0;
    op_b   = '0;
    op_sub = 1'b0;
    unique case (cmd.src)
      SRC_SQ: begin
        op_a = AW'(dmag[cmd.idx]);
        op_b = BW'(dmag[cmd.idx]);
      end
      SRC_DOT: begin
        op_a   = AW'(dvmag[cmd.idx]);
        op_b   = BW'(umag[cmd.idx]);
        op_sub = d[cmd.idx][DW-1] ^ dv[cmd.idx][DW-1];
      end
      SRC_SPR: begin
        op_a = AW'(stmag);
        op_b = BW'(stiff);
      end
      SRC_DMP: begin
        op_a = AW'(proj);
        op_b = BW'(dampf);
      end
      SRC_FRC: begin
        op_a = AW'(rmag);
        op_b = BW'(umag[cmd.idx]);
      end
    endcase
  end

  assign digit  = op_b[cmd.dig*DG +: DG];
  assign prod   = op_a * digit;
  assign addend = ACW'(prod) << (DG * cmd.dig);
  assign base   = cmd.clr ? '0 : acc;

  assign rem_t = {rem[REMW-3:0], rad[SQW-1 -: 2]};
  assign trial = REMW'({root, 2'b01});

  assign acc_abs  = acc[ACW-1] ? -acc : acc;
  assign dmag_sat = sat_shift(acc);
  assign spr_s    = sneg ? -SW'(smag) : SW'(smag);
  assign dmp_s    = dneg ? -SW'(dmag_sat) : SW'(dmag_sat);
  assign rsum     = spr_s + dmp_s;
  assign rabs     = rsum[SW-1] ? -rsum : rsum;

  assign fmag = acc[FB +: MW];
  assign fneg = d[cmd.idx][DW-1] ^ rneg;
  assign fval = fneg ? -CW'(fmag) : CW'(fmag);

  // control state and registers
  always_ff @(posedge clk) begin
    if (rst) begin
      stiff  <= '0;
      dampf  <= '0;
      rest   <= '0;
      en     <= 1'b1;
      hfree  <= 1'b0;
      hvalid <= 1'b0;
    end else begin
      if (cfg_valid) begin
        unique case (cfg_reg_t'(cfg_index))
          REG_STIFFNESS: stiff <= cfg_data;
          REG_DAMPING:   dampf <= cfg_data;
          REG_REST:      rest  <= cfg_data;
          REG_ENABLE:    en    <= cfg_data[0];
        endcase
      end
      if (cmd.op == OP_LOAD) begin
        if (!in_item.end_select) begin
          hfree  <= in_item.particle_free;
          hvalid <= 1'b1;
        end else begin
          hvalid <= 1'b0;
        end
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    unique case (cmd.op)
      OP_NONE: begin
      end
      OP_LOAD: begin
        if (!in_item.end_select) begin
          for (int i = 0; i < NAXIS; i++) begin
            hv[i]         <= posv[i];
            hv[NAXIS + i] <= velv[i];
          end
        end else begin
          for (int i = 0; i < NAXIS; i++) begin
            d[i]  <= {hv[i][CW-1], hv[i]} - {posv[i][CW-1], posv[i]};
            dv[i] <= {hv[NAXIS + i][CW-1], hv[NAXIS + i]} - {velv[i][CW-1], velv[i]};
          end
          bfree <= in_item.particle_free;
          zflag <= !status.go;
        end
      end
      OP_MAC: begin
        acc <= op_sub ? base - addend : base + addend;
      end
      OP_SQRT_INIT: begin
        rad  <= acc[SQW-1:0];
        root <= '0;
        rem  <= '0;
      end
      OP_SQRT_STEP: begin
        rad <= rad << 2;
        if (rem_t >= trial) begin
          rem  <= rem_t - trial;
          root <= {root[RTW-2:0], 1'b1};
        end else begin
          rem  <= rem_t;
          root <= {root[RTW-2:0], 1'b0};
        end
      end
      OP_DIV_INIT: begin
        for (int i = 0; i < NAXIS; i++) begin
          dr[i] <= RTW'(dmag[i] >> 1);
          nb[i] <= dmag[i][0];
          q[i]  <= '0;
        end
      end
      OP_DIV_STEP: begin
        for (int i = 0; i < NAXIS; i++) begin
          nb[i] <= 1'b0;
          if ({dr[i], nb[i]} >= {1'b0, root}) begin
            dr[i] <= RTW'({dr[i], nb[i]} - {1'b0, root});
            q[i]  <= {q[i][QW-2:0], 1'b1};
          end else begin
            dr[i] <= {dr[i][RTW-2:0], nb[i]};
            q[i]  <= {q[i][QW-2:0], 1'b0};
          end
        end
      end
      OP_DOT_SAVE: begin
        dneg <= !acc[ACW-1];
        proj <= acc_abs[FB +: PW];
      end
      OP_SPR_SAVE: begin
        smag <= sat_shift(acc);
        sneg <= !stretch[STW-1];
      end
      OP_DMP_SAVE: begin
        rneg <= rsum[SW-1];
        rmag <= (|rabs[SW-1:MW]) ? SAT_MAX : rabs[MW-1:0];
      end
      OP_FRC_SAVE: begin
        f[cmd.idx] <= fval;
      end
      OP_OUT: begin
        out_item.force_x         <= zflag ? '0 : f[0];
        out_item.force_y         <= zflag ? '0 : f[1];
        out_item.force_z         <= zflag ? '0 : f[2];
        out_item.apply_to_first  <= !zflag && hfree;
        out_item.apply_to_second <= !zflag && bfree;
      end
    endcase
  end

endmodule

// ===== sv/damped_spring_force_3d_core.sv =====
// ---------------------------------------------------------------------------
// damped_spring_force_3d_core
// damped spring force between two particle ends in Q16.16
// ---------------------------------------------------------------------------
// channel  dir  transfer when         carries
// item     in   valid & ready         one particle end
// result   out  valid & ready         force on first end and apply flags
// cfg      in   valid & ready (!rst)  register index and value
//
// a first end leaves the input ready again in the next cycle; a second end holds
// the input from its transfer to the next free input slot, set by the
// one-bit-per-cycle square root (33 steps), the three parallel dividers (17
// steps) and the shared multiplier (eleven products of three digits each)
// a second end with no held first end, spring off or both ends fixed skips the
// computation and yields a zero force with both flags clear
// reset clears the held end and the registers; the spring starts enabled
// a waiting result does not block the next item; a new result waits for it
// ---------------------------------------------------------------------------
`include "damped_spring_force_3d_core_defines.svh"

module damped_spring_force_3d_core (
  input  logic          clk,
  input  logic          rst,
  dsf_item_if.sink      item,
  dsf_result_if.source  result,
  dsf_cfg_if.sink       cfg
);
  import dsf_pkg::*;

  cmd_t      cmd;
  status_t   status;
  in_item_t  in_item;
  out_item_t out_item;

  assign in_item.end_select    = item.end_select;
  assign in_item.pos_x         = item.pos_x;
  assign in_item.pos_y         = item.pos_y;
  assign in_item.pos_z         = item.pos_z;
  assign in_item.vel_x         = item.vel_x;
  assign in_item.vel_y         = item.vel_y;
  assign in_item.vel_z         = item.vel_z;
  assign in_item.particle_free = item.particle_free;

  assign result.force_x         = out_item.force_x;
  assign result.force_y         = out_item.force_y;
  assign result.force_z         = out_item.force_z;
  assign result.apply_to_first  = out_item.apply_to_first;
  assign result.apply_to_second = out_item.apply_to_second;

  assign cfg.ready = !rst;

  dsf_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (item.valid),
    .in_ready  (item.ready),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .status    (status),
    .cmd       (cmd)
  );

  dsf_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .in_item   (in_item),
    .out_item  (out_item),
    .cfg_valid (cfg.valid),
    .cfg_index (cfg.index),
    .cfg_data  (cfg.data)
  );

  `DSF_ASSERT_NXT(a_second_end_busy, item.valid && item.ready && item.end_select, !item.ready, "input taken during a spring computation")
  `DSF_ASSERT_NXT(a_first_end_quick, item.valid && item.ready && !item.end_select, item.ready, "first end held up the input")
  `DSF_ASSERT_IMP(a_zero_when_unused, result.valid && !result.apply_to_first && !result.apply_to_second, result.force_x == '0 && result.force_y == '0 && result.force_z == '0, "force without any end taking it")

endmodule
